// File: rtl/llex_pkg.sv
package llex_pkg;

  localparam int VALUE_WIDTH = 31;
  localparam int CONST_W     = 31;

  localparam logic [2:0] KIND_LEFT   = 3'd0;
  localparam logic [2:0] KIND_RIGHT  = 3'd1;
  localparam logic [2:0] KIND_QUOTE  = 3'd2;
  localparam logic [2:0] KIND_SYMCH  = 3'd3;
  localparam logic [2:0] KIND_SYMEND = 3'd4;
  localparam logic [2:0] KIND_CONST  = 3'd5;
  localparam logic [2:0] KIND_ERROR  = 3'd6;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         symbol_char;
    logic [CONST_W-1:0] const_value;
    logic               overflow;
    logic               last;
  } out_item_t;

  // up to two results from one input word, first one always in item0
  typedef struct packed {
    logic      wr0;
    logic      wr1;
    out_item_t item0;
    out_item_t item1;
  } push_t;

endpackage

// File: rtl/lisp_token_lexer.sv
// a word's results are written into the queue when the byte is taken and reach
// out_ through the output register; a second result of the same byte follows it
// throughput: one byte per cycle, results one per cycle while out_stall is low,
// via a four-entry queue; in_stall rises while fewer than two entries are free
// reset (rst_n low, synchronous) returns the lexer to idle with a zero
// constant and empties the queue and the output register
module lisp_token_lexer
  import llex_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic  accept;
  logic  full;
  push_t push;

  assign in_stall = full;
  assign accept   = in_valid & ~full;

  llex_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_item),
    .push    (push)
  );

  llex_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// File: rtl/llex_front.sv
module llex_front
  import llex_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t in_item,
  output push_t    push
);

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_SYM   = 2'd1;
  localparam logic [1:0] MODE_CONST = 2'd2;

  localparam logic [7:0] CH_LEFT  = 8'h28;
  localparam logic [7:0] CH_RIGHT = 8'h29;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int EXT_W = VALUE_WIDTH + 4;

  logic [1:0]             mode_r, mode_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic                   ovf_r, ovf_nxt;

  logic [7:0]       c;
  logic             is_space, is_sym, is_digit;
  logic [3:0]       digit;
  logic [EXT_W-1:0] acc_ext, acc_next_ext;

  logic                   f_valid;
  out_item_t              f_item;
  logic [1:0]             f_mode;
  logic [VALUE_WIDTH-1:0] f_acc;

  logic      p_valid;
  out_item_t p_item;

  function automatic out_item_t mk_item(logic [2:0] kind, logic [7:0] ch,
                                        logic [CONST_W-1:0] val, logic ovf);
    out_item_t r;
    r.kind        = kind;
    r.symbol_char = ch;
    r.const_value = val;
    r.overflow    = ovf;
    r.last        = 1'b0;
    return r;
  endfunction

  assign c        = in_item.char_byte;
  assign is_space = c inside {8'd32, [8'd9:8'd13]};
  assign is_sym   = c inside {[8'h41:8'h5a], [8'h61:8'h7a], CH_PLUS, CH_MINUS,
                              CH_STAR, CH_SLASH};
  assign is_digit = c inside {[CH_ZERO:CH_NINE]};
  assign digit    = c[3:0];

  // acc * 10 + d, saturates when anything lands above the value width
  assign acc_ext      = EXT_W'(acc_r);
  assign acc_next_ext = (acc_ext << 3) + (acc_ext << 1) + EXT_W'(digit);

  // a byte seen with no symbol or constant open
  always_comb begin
    f_valid = 1'b0;
    f_item  = mk_item(KIND_ERROR, 8'd0, '0, 1'b0);
    f_mode  = MODE_IDLE;
    f_acc   = '0;
    if (is_space) begin
      f_valid = 1'b0;
    end else if (c == CH_LEFT) begin
      f_valid = 1'b1;
      f_item  = mk_item(KIND_LEFT, 8'd0, '0, 1'b0);
    end else if (c == CH_RIGHT) begin
      f_valid = 1'b1;
      f_item  = mk_item(KIND_RIGHT, 8'd0, '0, 1'b0);
    end else if (c == CH_QUOTE) begin
      f_valid = 1'b1;
      f_item  = mk_item(KIND_QUOTE, 8'd0, '0, 1'b0);
    end else if (is_sym) begin
      f_valid = 1'b1;
      f_item  = mk_item(KIND_SYMCH, c, '0, 1'b0);
      f_mode  = MODE_SYM;
    end else if (is_digit) begin
      f_acc  = VALUE_WIDTH'(digit);
      f_mode = MODE_CONST;
    end else begin
      f_valid = 1'b1;
    end
  end

  always_comb begin
    p_valid  = 1'b0;
    p_item   = mk_item(KIND_SYMEND, 8'd0, '0, 1'b0);
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    ovf_nxt  = ovf_r;
    push     = '0;

    if (in_item.end_of_input) begin
      if (mode_r == MODE_SYM) begin
        p_valid = 1'b1;
      end else if (mode_r == MODE_CONST) begin
        p_valid = 1'b1;
        p_item  = mk_item(KIND_CONST, 8'd0, CONST_W'(acc_r), ovf_r);
      end
      mode_nxt = MODE_IDLE;
      acc_nxt  = '0;
      ovf_nxt  = 1'b0;
    end else begin
      case (mode_r)
        MODE_SYM: begin
          if (is_sym) begin
            p_valid = 1'b1;
            p_item  = mk_item(KIND_SYMCH, c, '0, 1'b0);
          end else begin
            p_valid  = 1'b1;
            mode_nxt = f_mode;
            acc_nxt  = f_acc;
            ovf_nxt  = 1'b0;
          end
        end
        MODE_CONST: begin
          if (is_digit) begin
            if (acc_next_ext[EXT_W-1:VALUE_WIDTH] != '0) begin
              acc_nxt = '1;
              ovf_nxt = 1'b1;
            end else begin
              acc_nxt = acc_next_ext[VALUE_WIDTH-1:0];
            end
          end else begin
            p_valid  = 1'b1;
            p_item   = mk_item(KIND_CONST, 8'd0, CONST_W'(acc_r), ovf_r);
            mode_nxt = f_mode;
            acc_nxt  = f_acc;
            ovf_nxt  = 1'b0;
          end
        end
        default: begin
          mode_nxt = f_mode;
          acc_nxt  = f_acc;
          ovf_nxt  = 1'b0;
        end
      endcase
    end

    // pack results in order; the fresh byte only follows a closed token
    if (p_valid) begin
      push.wr0   = accept;
      push.item0 = p_item;
      if (!in_item.end_of_input && (mode_r == MODE_SYM || mode_r == MODE_CONST) &&
          !(mode_r == MODE_SYM && is_sym) && !(mode_r == MODE_CONST && is_digit)) begin
        push.wr1   = accept & f_valid;
        push.item1 = f_item;
      end
    end else if (!in_item.end_of_input && mode_r != MODE_SYM && mode_r != MODE_CONST) begin
      push.wr0   = accept & f_valid;
      push.item0 = f_item;
    end
    push.item0.last = !push.wr1;
    push.item1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      acc_r  <= '0;
      ovf_r  <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

// File: rtl/llex_queue.sv
module llex_queue
  import llex_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  push_t     push,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  out_item_t mem [QUEUE_DEPTH];

  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r;

  logic [1:0]        n_push;
  logic              pop;
  logic [QPTR_W-1:0] wr_ptr_plus1;

  assign n_push       = {1'b0, push.wr0} + {1'b0, push.wr1};
  assign pop          = (count_r != '0) && (!out_valid_r || !out_stall);
  assign wr_ptr_plus1 = wr_ptr_r + QPTR_W'(1);

  assign wr_ptr_nxt    = wr_ptr_r + QPTR_W'(n_push);
  assign rd_ptr_nxt    = rd_ptr_r + QPTR_W'(pop);
  assign count_nxt     = count_r + QCNT_W'(n_push) - QCNT_W'(pop);
  assign out_valid_nxt = pop | (out_valid_r & out_stall);

  // room for two results is needed before taking the next byte
  assign full      = count_r > QCNT_W'(QUEUE_DEPTH - 2);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (push.wr0) begin
      mem[wr_ptr_r] <= push.item0;
    end
    if (push.wr1) begin
      mem[wr_ptr_plus1] <= push.item1;
    end
    if (pop) begin
      out_item_r <= mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: test/lisp_token_lexer_tb.sv
module lisp_token_lexer_tb;
  import llex_pkg::*;

  typedef enum logic [1:0] {
    LX_IDLE  = 2'd0,
    LX_SYM   = 2'd1,
    LX_CONST = 2'd2
  } lex_mode_t;

  // one input word, optionally with its tokens typed in by hand
  typedef struct packed {
    in_item_t   word;
    logic       known;
    logic [1:0] n;
    out_item_t  r0;
    out_item_t  r1;
  } byte_note_t;

  localparam longint unsigned ACC_MAX = (64'd1 << VALUE_WIDTH) - 64'd1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_WORDS = 267;

  localparam logic [7:0] CH_OPEN  = "(";
  localparam logic [7:0] CH_CLOSE = ")";
  localparam logic [7:0] CH_QUOTE = "'";
  localparam logic [7:0] CH_ZERO  = "0";

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  int          fail_count = 0;
  int          bytes_sent = 0;
  int          bytes_taken = 0;
  int          tokens_checked = 0;
  int          consts_seen = 0;
  int          sat_seen = 0;
  int          cycles = 0;

  byte_note_t  note_q[$];
  out_item_t   token_q[$];
  byte_note_t  dir_rows [26];

  // lexer state as predicted
  lex_mode_t       lx_mode = LX_IDLE;
  longint unsigned lx_acc = 0;
  logic            lx_ovf = 1'b0;
  out_item_t       lx_out [2];
  int              lx_n = 0;

  lisp_token_lexer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic out_item_t tk(logic [2:0] kind, logic [7:0] ch, longint unsigned val,
                                   logic ovf, logic last);
    out_item_t t;
    t.kind        = kind;
    t.symbol_char = ch;
    t.const_value = val[CONST_W-1:0];
    t.overflow    = ovf;
    t.last        = last;
    return t;
  endfunction

  function automatic byte_note_t dr(logic [7:0] c, logic eoi, logic known, logic [1:0] n,
                                    out_item_t r0, out_item_t r1);
    byte_note_t b;
    b.word.char_byte    = c;
    b.word.end_of_input = eoi;
    b.known             = known;
    b.n                 = n;
    b.r0                = r0;
    b.r1                = r1;
    return b;
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_sym_char(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
           c == "+" || c == "-" || c == "*" || c == "/";
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function void lx_put(logic [2:0] kind, logic [7:0] ch, longint unsigned val, logic ovf);
    lx_out[lx_n] = tk(kind, ch, val, ovf, 1'b0);
    lx_n++;
  endfunction

  function void lx_const_out();
    lx_put(KIND_CONST, 8'd0, lx_acc, lx_ovf);
    lx_acc  = 0;
    lx_ovf  = 1'b0;
    lx_mode = LX_IDLE;
  endfunction

  function void lx_fresh(logic [7:0] c);
    lx_mode = LX_IDLE;
    if (is_space(c)) begin
      return;
    end
    if (c == CH_OPEN) begin
      lx_put(KIND_LEFT, 8'd0, 0, 1'b0);
    end else if (c == CH_CLOSE) begin
      lx_put(KIND_RIGHT, 8'd0, 0, 1'b0);
    end else if (c == CH_QUOTE) begin
      lx_put(KIND_QUOTE, 8'd0, 0, 1'b0);
    end else if (is_sym_char(c)) begin
      lx_put(KIND_SYMCH, c, 0, 1'b0);
      lx_mode = LX_SYM;
    end else if (is_digit(c)) begin
      lx_acc  = 64'(c) - 64'(CH_ZERO);
      lx_ovf  = 1'b0;
      lx_mode = LX_CONST;
    end else begin
      lx_put(KIND_ERROR, 8'd0, 0, 1'b0);
    end
  endfunction

  // works out the tokens one accepted word causes and advances the lexer state
  function void lx_byte(in_item_t w);
    logic [7:0]      c;
    longint unsigned d;
    c    = w.char_byte;
    lx_n = 0;
    if (w.end_of_input) begin
      if (lx_mode == LX_SYM) begin
        lx_put(KIND_SYMEND, 8'd0, 0, 1'b0);
      end else if (lx_mode == LX_CONST) begin
        lx_const_out();
      end
      lx_mode = LX_IDLE;
      lx_acc  = 0;
      lx_ovf  = 1'b0;
    end else if (lx_mode == LX_SYM) begin
      if (is_sym_char(c)) begin
        lx_put(KIND_SYMCH, c, 0, 1'b0);
      end else begin
        lx_put(KIND_SYMEND, 8'd0, 0, 1'b0);
        lx_fresh(c);
      end
    end else if (lx_mode == LX_CONST) begin
      if (is_digit(c)) begin
        d = 64'(c) - 64'(CH_ZERO);
        // saturate rather than wrap
        if (lx_acc > (ACC_MAX - d) / 10) begin
          lx_acc = ACC_MAX;
          lx_ovf = 1'b1;
        end else begin
          lx_acc = lx_acc * 10 + d;
        end
      end else begin
        lx_const_out();
        lx_fresh(c);
      end
    end else begin
      lx_fresh(c);
    end
    if (lx_n > 0) begin
      lx_out[lx_n-1].last = 1'b1;
    end
  endfunction

  function void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : token_monitor
    byte_note_t note;
    out_item_t  want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        note = note_q.pop_front();
        lx_byte(in_item);
        // hand-typed rows override the prediction
        if (note.known) begin
          lx_n      = note.n;
          lx_out[0] = note.r0;
          lx_out[1] = note.r1;
        end
        for (int i = 0; i < lx_n; i++) begin
          token_q.push_back(lx_out[i]);
        end
        bytes_taken++;
      end
      if (out_valid && !out_stall) begin
        if (token_q.size() == 0) begin
          $error("token kind %0d with nothing expected", out_item.kind);
          fail_count++;
        end else begin
          want = token_q.pop_front();
          check_field("kind", want.kind, out_item.kind);
          check_field("symbol_char", want.symbol_char, out_item.symbol_char);
          check_field("const_value", want.const_value, out_item.const_value);
          check_field("overflow", want.overflow, out_item.overflow);
          check_field("last", want.last, out_item.last);
          tokens_checked++;
          if (out_item.kind == KIND_CONST) begin
            consts_seen++;
            if (out_item.overflow) begin
              sat_seen++;
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < sink_idle_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("lisp_token_lexer verification failed");
      $finish;
    end
  end

  task automatic push_word(input byte_note_t note);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    note_q.push_back(note);
    in_valid <= 1'b1;
    in_item  <= note.word;
    do begin
      @(posedge clk);
    end while (in_stall);
    bytes_sent++;
  endtask

  task automatic push_byte(input logic [7:0] c, input logic eoi);
    push_word(dr(c, eoi, 1'b0, 2'd0, '0, '0));
  endtask

  function automatic logic [7:0] pick_sym();
    case ($urandom_range(0, 5))
      0: return 8'("A" + $urandom_range(0, 25));
      1: return 8'("a" + $urandom_range(0, 25));
      2: return "+";
      3: return "-";
      4: return "*";
      default: return "/";
    endcase
  endfunction

  // one token's worth of bytes, mostly well formed
  task automatic send_token();
    int    pick;
    int    len;
    string digits;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      len = $urandom_range(1, 6);
      repeat (len) push_byte(pick_sym(), 1'b0);
    end else if (pick < 50) begin
      case ($urandom_range(0, 5))
        0: digits = "2147483647";
        1: digits = "2147483648";
        2: begin
          digits = "";
          len = $urandom_range(10, 13);
          repeat (len) push_byte(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
        end
        default: begin
          digits = "";
          len = $urandom_range(1, 4);
          repeat (len) push_byte(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
        end
      endcase
      for (int i = 0; i < digits.len(); i++) begin
        push_byte(digits[i], 1'b0);
      end
    end else if (pick < 62) begin
      case ($urandom_range(0, 2))
        0: push_byte(CH_OPEN, 1'b0);
        1: push_byte(CH_CLOSE, 1'b0);
        default: push_byte(CH_QUOTE, 1'b0);
      endcase
    end else if (pick < 74) begin
      len = $urandom_range(0, 5);
      push_byte((len == 5) ? 8'd32 : 8'(9 + len), 1'b0);
    end else if (pick < 84) begin
      // character byte is don't-care here, so let it roam
      push_byte(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      push_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  initial begin
    int goal;
    dir_rows[0]  = dr(CH_OPEN, 1'b0, 1'b1, 2'd1, tk(KIND_LEFT, 0, 0, 0, 1), '0);
    dir_rows[1]  = dr(CH_CLOSE, 1'b0, 1'b1, 2'd1, tk(KIND_RIGHT, 0, 0, 0, 1), '0);
    dir_rows[2]  = dr(CH_QUOTE, 1'b0, 1'b1, 2'd1, tk(KIND_QUOTE, 0, 0, 0, 1), '0);
    dir_rows[3]  = dr(8'h00, 1'b0, 1'b1, 2'd1, tk(KIND_ERROR, 0, 0, 0, 1), '0);
    dir_rows[4]  = dr(8'hFF, 1'b0, 1'b1, 2'd1, tk(KIND_ERROR, 0, 0, 0, 1), '0);
    dir_rows[5]  = dr(8'd32, 1'b0, 1'b1, 2'd0, '0, '0);
    dir_rows[6]  = dr(8'd9, 1'b0, 1'b1, 2'd0, '0, '0);
    dir_rows[7]  = dr(8'd13, 1'b0, 1'b1, 2'd0, '0, '0);
    dir_rows[8]  = dr("a", 1'b1, 1'b1, 2'd0, '0, '0);
    dir_rows[9]  = dr("-", 1'b0, 1'b1, 2'd1, tk(KIND_SYMCH, "-", 0, 0, 1), '0);
    dir_rows[10] = dr("7", 1'b0, 1'b1, 2'd1, tk(KIND_SYMEND, 0, 0, 0, 1), '0);
    dir_rows[11] = dr(8'h00, 1'b1, 1'b1, 2'd1, tk(KIND_CONST, 0, 7, 0, 1), '0);
    // ten nines run past the top of the constant range
    for (int i = 12; i < 22; i++) begin
      dir_rows[i] = dr("9", 1'b0, 1'b0, 2'd0, '0, '0);
    end
    dir_rows[22] = dr("*", 1'b0, 1'b1, 2'd2, tk(KIND_CONST, 0, ACC_MAX, 1, 0),
                      tk(KIND_SYMCH, "*", 0, 0, 1));
    dir_rows[23] = dr(8'h80, 1'b0, 1'b1, 2'd2, tk(KIND_SYMEND, 0, 0, 0, 0),
                      tk(KIND_ERROR, 0, 0, 0, 1));
    dir_rows[24] = dr("z", 1'b0, 1'b1, 2'd1, tk(KIND_SYMCH, "z", 0, 0, 1), '0);
    dir_rows[25] = dr(8'h00, 1'b1, 1'b1, 2'd1, tk(KIND_SYMEND, 0, 0, 0, 1), '0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    src_idle_pct  = 21;
    sink_idle_pct = 52;
    foreach (dir_rows[i]) begin
      push_word(dir_rows[i]);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 21;
          sink_idle_pct = 52;
        end
        1: begin
          src_idle_pct  = 52;
          sink_idle_pct = 21;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      goal = bytes_sent + PHASE_WORDS;
      while (bytes_sent < goal) begin
        send_token();
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (token_q.size() != 0) begin
      @(posedge clk);
    end
    // let any stray token surface
    repeat (8) @(posedge clk);

    $display("%0d bytes lexed under three stall mixes, %0d tokens compared", bytes_taken,
             tokens_checked);
    $display("%0d constants seen, %0d of them saturated", consts_seen, sat_seen);
    if (fail_count == 0) begin
      $display("lisp_token_lexer verification clean");
    end else begin
      $display("lisp_token_lexer verification failed");
    end
    $finish;
  end

endmodule
